### src/modulus_to_velocity_kernel_assert.svh
// assertion macros for the modulus to velocity kernel checker
`ifndef MODULUS_TO_VELOCITY_KERNEL_ASSERT_SVH
`define MODULUS_TO_VELOCITY_KERNEL_ASSERT_SVH

// clocked check, off while reset is asserted
`define MTVK_CHK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define MTVK_CHK_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mtvk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtvk_pkg
// shared constants, codes and lane result type for the speed kernel converter
// ----------------------------------------------------------------------------
package mtvk_pkg;

    localparam int NUM_LANES  = 3;
    localparam int DIV_W      = 48;
    localparam int SQRT_STEPS = 32;
    localparam int LANE_LAT   = DIV_W + 3;

    localparam logic [1:0] REQ_LOVE     = 2'd0;
    localparam logic [1:0] REQ_RAYLEIGH = 2'd1;
    localparam logic [1:0] REQ_ACOUSTIC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [56:0] SPD_MAX_POS = 57'd140737488355327;
    localparam logic [56:0] SPD_MAX_NEG = 57'd140737488355328;
    localparam logic [60:0] TERM_CLAMP  = 61'd1152921504606846976;

    localparam logic signed [63:0] ACC_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] ACC_MIN = -64'sd140737488355328;

    typedef struct packed {
        logic [47:0]        speed;
        logic signed [61:0] term;
        logic               sat;
    } lane_res_t;

endpackage

### src/mtvk_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtvk_lane
// one modulus lane: restoring divide and square root, one bit per stage,
// then the speed kernel and the density term with clamping
// ----------------------------------------------------------------------------
module mtvk_lane (
    input  logic                clk,
    input  logic                en,
    input  logic                act,
    input  logic [31:0]         modulus,
    input  logic signed [31:0]  kernel,
    input  logic [31:0]         density,
    output mtvk_pkg::lane_res_t res
);
    import mtvk_pkg::*;

    logic [DIV_W-1:0] nq_reg   [0:DIV_W];
    logic [31:0]      drem_reg [0:DIV_W];
    logic [31:0]      rho_reg  [0:DIV_W];
    logic [31:0]      kmag_reg [0:DIV_W];
    logic             kneg_reg [0:DIV_W];
    logic             act_reg  [0:DIV_W];
    logic [31:0]      root_reg [0:DIV_W];
    logic [63:0]      prod_reg [0:SQRT_STEPS];
    logic [32:0]      srem_reg [0:SQRT_STEPS];

    logic [31:0] kbits;
    logic [63:0] wk_reg;
    logic [55:0] hi_reg;
    logic [55:0] lo_reg;
    logic        kneg_a_reg;
    logic        act_a_reg;

    logic [56:0] spd_mag;
    logic        spd_sat;
    logic [47:0] spd_clamped;
    logic        hi_big;
    logic [60:0] term_raw;
    logic        term_sat;
    logic [60:0] term_mag;

    assign kbits = kernel;

    // input stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]   <= {modulus, 16'd0};
            drem_reg[0] <= '0;
            rho_reg[0]  <= density;
            kneg_reg[0] <= kbits[31];
            kmag_reg[0] <= kbits[31] ? (32'd0 - kbits) : kbits;
            act_reg[0]  <= act;
            prod_reg[0] <= modulus * density;
            srem_reg[0] <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar i = 1; i <= DIV_W; i++)
    begin : g_step
        logic [32:0] dtrial;
        logic [32:0] dsub;

        assign dtrial = {drem_reg[i-1], nq_reg[i-1][DIV_W-1]};
        assign dsub   = dtrial - {1'b0, rho_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (dtrial >= {1'b0, rho_reg[i-1]})
                begin
                    drem_reg[i] <= dsub[31:0];
                    nq_reg[i]   <= {nq_reg[i-1][DIV_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[i] <= dtrial[31:0];
                    nq_reg[i]   <= {nq_reg[i-1][DIV_W-2:0], 1'b0};
                end
                rho_reg[i]  <= rho_reg[i-1];
                kmag_reg[i] <= kmag_reg[i-1];
                kneg_reg[i] <= kneg_reg[i-1];
                act_reg[i]  <= act_reg[i-1];
            end
        end

        if (i <= SQRT_STEPS)
        begin : g_sqrt
            logic [34:0] strial;
            logic [34:0] stest;
            logic [34:0] ssub;

            assign strial = {srem_reg[i-1], prod_reg[i-1][63:62]};
            assign stest  = {1'b0, root_reg[i-1], 2'b01};
            assign ssub   = strial - stest;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (strial >= stest)
                    begin
                        srem_reg[i] <= ssub[32:0];
                        root_reg[i] <= {root_reg[i-1][30:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg[i] <= strial[32:0];
                        root_reg[i] <= {root_reg[i-1][30:0], 1'b0};
                    end
                    prod_reg[i] <= {prod_reg[i-1][61:0], 2'b00};
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[i] <= root_reg[i-1];
                end
            end
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wk_reg     <= root_reg[DIV_W] * kmag_reg[DIV_W];
            hi_reg     <= nq_reg[DIV_W][47:24] * kmag_reg[DIV_W];
            lo_reg     <= nq_reg[DIV_W][23:0] * kmag_reg[DIV_W];
            kneg_a_reg <= kneg_reg[DIV_W];
            act_a_reg  <= act_reg[DIV_W];
        end
    end

    always_comb
    begin
        spd_mag     = wk_reg[63:7];
        spd_sat     = kneg_a_reg ? (spd_mag > SPD_MAX_NEG) : (spd_mag > SPD_MAX_POS);
        spd_clamped = spd_sat ? (kneg_a_reg ? SPD_MAX_NEG[47:0] : SPD_MAX_POS[47:0])
                              : spd_mag[47:0];
        hi_big      = |hi_reg[55:52];
        term_raw    = {1'b0, hi_reg[51:0], 8'd0} + {21'd0, lo_reg[55:16]};
        term_sat    = hi_big || (term_raw > TERM_CLAMP);
        term_mag    = term_sat ? TERM_CLAMP : term_raw;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (act_a_reg)
            begin
                res.speed <= kneg_a_reg ? (48'd0 - spd_clamped) : spd_clamped;
                res.term  <= kneg_a_reg ? (62'sd0 - $signed({1'b0, term_mag}))
                                        : $signed({1'b0, term_mag});
                res.sat   <= spd_sat || term_sat;
            end
            else
            begin
                res <= '0;
            end
        end
    end

endmodule

### src/mtvk_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtvk_merge
// sums the lane density terms with the density kernel, saturates and
// forms the status code
// ----------------------------------------------------------------------------
module mtvk_merge (
    input  logic                       clk,
    input  logic                       en,
    input  mtvk_pkg::lane_res_t        res [0:2],
    input  logic signed [31:0]         dk,
    input  logic                       rho_zero,
    output logic signed [47:0]         sk_a,
    output logic signed [47:0]         sk_b,
    output logic signed [47:0]         sk_c,
    output logic signed [47:0]         ndk,
    output logic [1:0]                 st
);
    import mtvk_pkg::*;

    logic signed [63:0] acc;
    logic signed [63:0] acc_sat;
    logic               acc_over;
    logic               any_sat;

    always_comb
    begin
        acc = 64'(dk);
        for (int j = 0; j < NUM_LANES; j++)
        begin
            acc = acc + 64'(res[j].term);
        end
        acc_over = (acc > ACC_MAX) || (acc < ACC_MIN);
        if (acc > ACC_MAX)
        begin
            acc_sat = ACC_MAX;
        end
        else if (acc < ACC_MIN)
        begin
            acc_sat = ACC_MIN;
        end
        else
        begin
            acc_sat = acc;
        end
        any_sat = acc_over || res[0].sat || res[1].sat || res[2].sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rho_zero)
            begin
                sk_a <= '0;
                sk_b <= '0;
                sk_c <= '0;
                ndk  <= '0;
                st   <= ST_ZERO;
            end
            else
            begin
                sk_a <= res[0].speed;
                sk_b <= res[1].speed;
                sk_c <= res[2].speed;
                ndk  <= acc_sat[47:0];
                st   <= any_sat ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

### src/modulus_to_velocity_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulus_to_velocity_kernel
// converts modulus kernels to wave speed kernels at one mesh point
// ----------------------------------------------------------------------------
// The input channel takes one word per point: request type, three moduli,
// their kernels, density and density kernel, under in_valid / in_ready.
// The output channel gives three speed kernels, the new density kernel and
// a status code under out_valid / out_ready.
// From input acceptance to out_valid a word passes one input stage,
// 48 divide stages (the 32 square root stages run beside the first 32 of them),
// a multiply stage, a clamp stage, the merge stage and the output register.
// Throughput is one word per cycle while in_ready is high; the three lanes run side by side.
// Reset clears all valid flags; the pipeline comes up empty and ready.
// When the receiver stalls the output register holds its word and the
// pipeline keeps moving as long as the stage in front of it is empty;
// in_ready falls only when both the merge stage and the output are full.
// ----------------------------------------------------------------------------
module modulus_to_velocity_kernel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [31:0]        modulus_a,
    input  logic [31:0]        modulus_b,
    input  logic [31:0]        modulus_c,
    input  logic signed [31:0] kernel_a,
    input  logic signed [31:0] kernel_b,
    input  logic signed [31:0] kernel_c,
    input  logic [31:0]        density,
    input  logic signed [31:0] density_kernel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] speed_kernel_a,
    output logic signed [47:0] speed_kernel_b,
    output logic signed [47:0] speed_kernel_c,
    output logic signed [47:0] new_density_kernel,
    output logic [1:0]         status
);
    import mtvk_pkg::*;

    logic               en;
    logic               act_a;
    logic               act_b;
    logic               act_c;
    lane_res_t          res [0:2];

    logic               v_reg  [0:LANE_LAT-1];
    logic signed [31:0] dk_reg [0:LANE_LAT-1];
    logic               rz_reg [0:LANE_LAT-1];
    logic               m_valid_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic signed [47:0] m_sk_a;
    logic signed [47:0] m_sk_b;
    logic signed [47:0] m_sk_c;
    logic signed [47:0] m_ndk;
    logic [1:0]         m_st;

    logic signed [47:0] sk_a_reg;
    logic signed [47:0] sk_b_reg;
    logic signed [47:0] sk_c_reg;
    logic signed [47:0] ndk_reg;
    logic [1:0]         st_reg;

    assign en       = !m_valid_reg || !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        act_a = req_type inside {REQ_LOVE, REQ_RAYLEIGH, REQ_ACOUSTIC};
        act_b = (req_type == REQ_RAYLEIGH);
        act_c = req_type inside {REQ_LOVE, REQ_RAYLEIGH};
    end

    mtvk_lane u_lane_a (
        .clk     (clk),
        .en      (en),
        .act     (act_a),
        .modulus (modulus_a),
        .kernel  (kernel_a),
        .density (density),
        .res     (res[0])
    );

    mtvk_lane u_lane_b (
        .clk     (clk),
        .en      (en),
        .act     (act_b),
        .modulus (modulus_b),
        .kernel  (kernel_b),
        .density (density),
        .res     (res[1])
    );

    mtvk_lane u_lane_c (
        .clk     (clk),
        .en      (en),
        .act     (act_c),
        .modulus (modulus_c),
        .kernel  (kernel_c),
        .density (density),
        .res     (res[2])
    );

    // side band delay line matching the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dk_reg[0] <= density_kernel;
            rz_reg[0] <= (density == 32'd0);
            for (int i = 1; i < LANE_LAT; i++)
            begin
                dk_reg[i] <= dk_reg[i-1];
                rz_reg[i] <= rz_reg[i-1];
            end
        end
    end

    mtvk_merge u_merge (
        .clk      (clk),
        .en       (en),
        .res      (res),
        .dk       (dk_reg[LANE_LAT-1]),
        .rho_zero (rz_reg[LANE_LAT-1]),
        .sk_a     (m_sk_a),
        .sk_b     (m_sk_b),
        .sk_c     (m_sk_c),
        .ndk      (m_ndk),
        .st       (m_st)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (en && m_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg[0] <= in_valid;
                for (int i = 1; i < LANE_LAT; i++)
                begin
                    v_reg[i] <= v_reg[i-1];
                end
                m_valid_reg <= v_reg[LANE_LAT-1];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (en && m_valid_reg)
        begin
            sk_a_reg <= m_sk_a;
            sk_b_reg <= m_sk_b;
            sk_c_reg <= m_sk_c;
            ndk_reg  <= m_ndk;
            st_reg   <= m_st;
        end
    end

    assign out_valid          = out_valid_reg;
    assign speed_kernel_a     = sk_a_reg;
    assign speed_kernel_b     = sk_b_reg;
    assign speed_kernel_c     = sk_c_reg;
    assign new_density_kernel = ndk_reg;
    assign status             = st_reg;

endmodule

### src/mtvk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtvk_checker
// port level checks for the speed kernel converter
// ----------------------------------------------------------------------------
`include "modulus_to_velocity_kernel_assert.svh"

module mtvk_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         req_type,
    input logic [31:0]        modulus_a,
    input logic [31:0]        modulus_b,
    input logic [31:0]        modulus_c,
    input logic signed [31:0] kernel_a,
    input logic signed [31:0] kernel_b,
    input logic signed [31:0] kernel_c,
    input logic [31:0]        density,
    input logic signed [31:0] density_kernel,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [47:0] speed_kernel_a,
    input logic signed [47:0] speed_kernel_b,
    input logic signed [47:0] speed_kernel_c,
    input logic signed [47:0] new_density_kernel,
    input logic [1:0]         status
);
    import mtvk_pkg::*;

    logic         stalled;
    logic [193:0] out_word;
    logic         kernels_zero;

    assign stalled      = out_valid && !out_ready;
    assign out_word     = {speed_kernel_a, speed_kernel_b, speed_kernel_c,
                           new_density_kernel, status};
    assign kernels_zero = (speed_kernel_a == 48'sd0) && (speed_kernel_b == 48'sd0)
                          && (speed_kernel_c == 48'sd0) && (new_density_kernel == 48'sd0);

    // stalled output word holds
    `MTVK_CHK(a_out_hold, stalled |=> out_valid && $stable(out_word), "stalled output word changed")

    // zero density gives all zero kernels
    `MTVK_CHK(a_zero_rho, out_valid && (status == ST_ZERO) |-> kernels_zero, "zero density word not cleared")

    // an empty output register never blocks the input
    `MTVK_CHK(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output")

    // reset empties the output
    `MTVK_CHK_ANY(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind modulus_to_velocity_kernel mtvk_checker u_mtvk_checker (.*);
